FILE: hw/rtl/programmable_sound_generator_defines.svh
// Assertion macros used by the sound generator checker.
// Depends on nothing; the including module supplies clk and rst.
`ifndef PROGRAMMABLE_SOUND_GENERATOR_DEFINES_SVH
`define PROGRAMMABLE_SOUND_GENERATOR_DEFINES_SVH

// Check a property outside reset.
`define PSG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define PSG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/psg_pkg.sv
// Shared types, command codes and envelope shape tables for the sound generator.
// Depends on nothing.
package psg_pkg;

  localparam int DivW = 24;
  localparam int DivCntW = 5;
  localparam int ToneW = 15;
  localparam int EnvW = 24;

  typedef enum logic [1:0] {
    CMD_SELECT = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SHAPE_LOW  = 2'd0,
    SHAPE_HIGH = 2'd1,
    SHAPE_UP   = 2'd2,
    SHAPE_DOWN = 2'd3
  } shape_kind_t;

  localparam logic [3:0] REG_SHAPE = 4'd13;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
    logic [DivW-1:0] rem;
  } div_status_t;

  // Segment kind of a shape in a phase.
  function automatic shape_kind_t shape_kind(input logic [3:0] shape, input logic phase);
    shape_kind_t k;
    k = SHAPE_LOW;
    if (!phase) begin
      k = (shape inside {4'd4, 4'd5, 4'd6, 4'd7, 4'd12, 4'd13, 4'd14, 4'd15}) ?
          SHAPE_UP : SHAPE_DOWN;
    end else begin
      case (shape)
        4'd8:    k = SHAPE_DOWN;
        4'd10:   k = SHAPE_UP;
        4'd11:   k = SHAPE_HIGH;
        4'd12:   k = SHAPE_UP;
        4'd13:   k = SHAPE_HIGH;
        4'd14:   k = SHAPE_DOWN;
        default: k = SHAPE_LOW;
      endcase
    end
    return k;
  endfunction

  function automatic logic shape_repeat(input logic [3:0] shape);
    return shape == 4'd8 || shape == 4'd10 || shape == 4'd12 || shape == 4'd14;
  endfunction

  // Envelope level for a segment kind and step.
  function automatic logic [3:0] env_level_of(input shape_kind_t k, input logic [3:0] step);
    logic [3:0] l;
    l = 4'd0;
    case (k)
      SHAPE_LOW:  l = 4'd0;
      SHAPE_HIGH: l = 4'd15;
      SHAPE_UP:   l = step;
      default:    l = 4'd15 - step;
    endcase
    return l;
  endfunction

endpackage

FILE: hw/rtl/psg_div.sv
// Restoring divider, one quotient bit per cycle, shared by the envelope and tone counters.
// Depends on psg_pkg.
module psg_div import psg_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DivW-1:0] dividend,
  input  logic [DivW-1:0] divisor,
  output div_status_t     status
);

  logic [DivCntW-1:0] cnt;
  logic [DivW-1:0]    dvd;
  logic [DivW-1:0]    dsr;
  logic [DivW-1:0]    rem;
  logic [DivW-1:0]    quo;
  logic               done;
  logic [DivW:0]      trial;
  logic               fits;

  assign trial = {rem, dvd[DivW-1]};
  assign fits  = trial >= {1'b0, dsr};

  // Shift in one dividend bit per cycle, subtract when it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DivCntW'(DivW);
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
        quo <= '0;
      end else if (cnt != '0) begin
        dvd <= dvd << 1;
        rem <= fits ? DivW'(trial - {1'b0, dsr}) : trial[DivW-1:0];
        quo <= {quo[DivW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) done <= 1'b1;
      end
    end
  end

  assign status = '{done: done, quo: quo, rem: rem};

endmodule

FILE: hw/rtl/programmable_sound_generator.sv
// Three-channel sound generator with a register-port command stream.
// Usage:
//  s_tuser carries the command (select, write, tick), s_tdata the byte.
//  Every accepted transaction yields one result transaction on m_* with the
//  three channel level codes held from the most recent tick.
// Sequence:
//  select and write: through ST_RESULT to the output register.
//  tick: noise catch-up in ST_NOISE, then five divisions on the one shared
//  restoring divider (envelope wrap, envelope step, three tone counters),
//  then ST_MIX and ST_RESULT. s_tready is high only in idle, so one
//  transaction is in work at a time.
// Stall:
//  The result sits in an output register; the next command is taken while
//  it waits. A finished result waits until the register frees up.
// Reset:
//  rst clears all registers, counters and levels; the noise shifter is set
//  to all ones. No clearing pass is needed.
module programmable_sound_generator import psg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data[7:0]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // level_a[3:0], level_b[7:4], level_c[11:8], zero
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NOISE, ST_ENV_GO, ST_ENV_WAIT, ST_STEP_GO, ST_STEP_WAIT,
    ST_TONE_GO, ST_TONE_WAIT, ST_MIX, ST_RESULT
  } state_t;

  state_t            state;
  logic [7:0]        regs [16];
  logic [3:0]        sel;
  logic [ToneW-1:0]  tone_count [3];
  logic [2:0]        tone_bit;
  logic [7:0]        noise_count;
  logic [16:0]       noise_shifter;
  logic              noise_bit;
  logic [EnvW-1:0]   env_count;
  logic              env_phase;
  logic [3:0]        env_level;
  logic [3:0]        level [3];
  logic [1:0]        ch;

  logic [7:0]        noise_len;
  logic [EnvW-1:0]   env_len;
  logic [EnvW-1:0]   env_dur;
  logic [ToneW-1:0]  tone_len;
  logic [11:0]       tone_period;
  logic              div_start;
  logic [DivW-1:0]   div_dividend;
  logic [DivW-1:0]   div_divisor;
  div_status_t       div_st;
  logic [3:0]        shape;
  cmd_t              cmd;

  assign cmd   = cmd_t'(s_tuser);
  assign shape = regs[REG_SHAPE][3:0];
  assign s_tready = (state == ST_IDLE);

  // Divider lengths from the period registers.
  assign noise_len = (regs[6][4:0] == 5'd0) ? 8'd1 : {regs[6][4:0], 3'b000};
  assign env_len   = ({regs[12], regs[11]} == 16'd0) ? EnvW'(128) :
                     {regs[12], regs[11], 8'h00};
  assign env_dur   = env_len >> 4;
  assign tone_period = {regs[{1'b0, ch, 1'b1}][3:0], regs[{1'b0, ch, 1'b0}]};
  assign tone_len  = (tone_period == 12'd0) ? ToneW'(1) : {tone_period, 3'b000};

  // Feed the shared divider for the active step.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      ST_ENV_GO: begin
        div_start    = 1'b1;
        div_dividend = env_count + 1'b1;
        div_divisor  = env_len;
      end
      ST_STEP_GO: begin
        div_start    = 1'b1;
        div_dividend = env_count;
        div_divisor  = env_dur;
      end
      ST_TONE_GO: begin
        div_start    = 1'b1;
        div_dividend = DivW'(ToneW'(tone_count[ch] + 1'b1));
        div_divisor  = DivW'(tone_len);
      end
      default: ;
    endcase
  end

  psg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_st)
  );

  // Sequencer and all generator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      for (int i = 0; i < 16; i++) regs[i] <= 8'd0;
      sel           <= 4'd0;
      for (int i = 0; i < 3; i++) begin
        tone_count[i] <= '0;
        level[i]      <= 4'd0;
      end
      tone_bit      <= 3'd0;
      noise_count   <= 8'd0;
      noise_shifter <= 17'h1FFFF;
      noise_bit     <= 1'b0;
      env_count     <= '0;
      env_phase     <= 1'b0;
      env_level     <= 4'd0;
      ch            <= 2'd0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_RESULT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_RESULT;
            case (cmd)
              CMD_SELECT: sel <= s_tdata[3:0];
              CMD_WRITE: begin
                regs[sel] <= s_tdata;
                if (sel == REG_SHAPE) begin
                  env_count <= '0;
                  env_phase <= 1'b0;
                  env_level <= env_level_of(shape_kind(s_tdata[3:0], 1'b0), 4'd0);
                end
              end
              CMD_TICK: begin
                noise_count <= noise_count + 1'b1;
                state       <= ST_NOISE;
              end
              default: ;
            endcase
          end
        end
        ST_NOISE: begin
          // Catch up one noise shift per cycle.
          if (noise_count >= noise_len) begin
            noise_count   <= noise_count - noise_len;
            noise_shifter <= {noise_shifter[0] ^ noise_shifter[4], noise_shifter[16:1]};
            noise_bit     <= noise_bit ^ noise_shifter[0];
          end else begin
            state <= ST_ENV_GO;
          end
        end
        ST_ENV_GO: state <= ST_ENV_WAIT;
        ST_ENV_WAIT: begin
          if (div_st.done) begin
            env_count <= div_st.rem;
            if (div_st.quo != '0) begin
              env_phase <= shape_repeat(shape) ? (env_phase ^ div_st.quo[0]) : 1'b1;
            end
            state <= ST_STEP_GO;
          end
        end
        ST_STEP_GO: state <= ST_STEP_WAIT;
        ST_STEP_WAIT: begin
          if (div_st.done) begin
            env_level <= env_level_of(shape_kind(shape, env_phase), div_st.quo[3:0]);
            ch        <= 2'd0;
            state     <= ST_TONE_GO;
          end
        end
        ST_TONE_GO: state <= ST_TONE_WAIT;
        ST_TONE_WAIT: begin
          if (div_st.done) begin
            tone_count[ch] <= div_st.rem[ToneW-1:0];
            tone_bit[ch]   <= tone_bit[ch] ^ div_st.quo[0];
            if (ch == 2'd2) begin
              state <= ST_MIX;
            end else begin
              ch    <= ch + 1'b1;
              state <= ST_TONE_GO;
            end
          end
        end
        ST_MIX: begin
          // Gate each channel by its tone and noise enables.
          for (int i = 0; i < 3; i++) begin
            if ((regs[7][i] | tone_bit[i]) & (regs[7][3+i] | noise_bit)) begin
              level[i] <= regs[8+i][4] ? env_level : regs[8+i][3:0];
            end else begin
              level[i] <= 4'd0;
            end
          end
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          // Load the output register once it is free.
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {4'd0, level[2], level[1], level[0]};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/psg_checker.sv
// Port-level checks for the sound generator, bound to the top level.
// Depends on psg_pkg and programmable_sound_generator_defines.svh.
`include "programmable_sound_generator_defines.svh"

module psg_checker import psg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  `PSG_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result after reset")
  `PSG_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "second accept")
  `PSG_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[15:12] == 4'd0), "pad bits set")
  `PSG_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result dropped")

endmodule

bind programmable_sound_generator psg_checker u_psg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
